// ===== rtl/stt_pkg.sv =====
// ----------------------------------------------------------------------------
// stt_pkg: shared types and constants of the source text tokeniser
// Token record, per-byte result bundle, token kinds and keyword table.
// ----------------------------------------------------------------------------
package stt_pkg;

  localparam int QUEUE_DEPTH = 2;

  localparam logic [4:0] KIND_NUMBER = 5'd0;
  localparam logic [4:0] KIND_IDENT  = 5'd1;
  localparam logic [4:0] KIND_ASSIGN = 5'd9;
  localparam logic [4:0] KIND_EQUAL  = 5'd10;
  localparam logic [4:0] KIND_PLUS   = 5'd17;
  localparam logic [4:0] KIND_MINUS  = 5'd18;
  localparam logic [4:0] KIND_STAR   = 5'd19;
  localparam logic [4:0] KIND_SLASH  = 5'd20;
  localparam logic [4:0] KIND_LBRACE = 5'd21;
  localparam logic [4:0] KIND_RBRACE = 5'd22;
  localparam logic [4:0] KIND_LPAREN = 5'd23;
  localparam logic [4:0] KIND_RPAREN = 5'd24;
  localparam logic [4:0] KIND_COMMA  = 5'd25;
  localparam logic [4:0] KIND_END    = 5'd26;
  localparam logic [4:0] KIND_ERROR  = 5'd27;

  localparam int KW_COUNT = 8;
  // keyword text packed first byte lowest
  localparam logic [63:0] KW_PACKED [KW_COUNT] = '{
    64'h0000_0074_6E69_7270,  // print
    64'h0000_0000_0000_6669,  // if
    64'h0000_0000_6573_6C65,  // else
    64'h0000_0065_6C69_6877,  // while
    64'h0000_0000_0000_6E66,  // fn
    64'h0000_6E72_7574_6572,  // return
    64'h0000_0000_6575_7274,  // true
    64'h0000_0065_736C_6166   // false
  };
  localparam logic [3:0] KW_LEN [KW_COUNT] = '{
    4'd5, 4'd2, 4'd4, 4'd5, 4'd2, 4'd6, 4'd4, 4'd5
  };
  localparam logic [4:0] KW_KIND [KW_COUNT] = '{
    5'd2, 5'd3, 5'd4, 5'd5, 5'd6, 5'd7, 5'd8, 5'd8
  };

  typedef enum logic [1:0] {
    MODE_IDLE     = 2'd0,
    MODE_NUMBER   = 2'd1,
    MODE_WORD     = 2'd2,
    MODE_OPERATOR = 2'd3
  } scan_mode_t;

  typedef struct packed {
    logic [4:0]  kind;
    logic [15:0] line;
    logic [15:0] column;
    logic [15:0] length;
    logic [7:0]  bad;
  } tok_t;

  typedef struct packed {
    logic [1:0]       count;
    tok_t [2:0]       tok;
  } bundle_t;

endpackage

// ===== rtl/stt_front.sv =====
// ----------------------------------------------------------------------------
// stt_front: scanner front end
// Accepts one byte a cycle while the queue is not full, updates the scan
// state and builds the bundle of up to three tokens that the byte causes.
// ----------------------------------------------------------------------------
module stt_front #(
  parameter int POSITION_BITS = 16,
  parameter int KEYWORD_BYTES = 6
) (
  input  logic              clk,
  input  logic              rst,
  input  logic [7:0]        char_byte,
  input  logic              final_byte,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic              q_full,
  output logic              q_push,
  output stt_pkg::bundle_t  q_data
);

  localparam int P  = POSITION_BITS;
  localparam int KB = 8 * KEYWORD_BYTES;
  localparam logic [P-1:0] POS_MAX = {P{1'b1}};

  localparam logic [7:0] CH_NL    = 8'h0A;
  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_EQ    = 8'h3D;

  stt_pkg::scan_mode_t mode, mode_next;
  logic [1:0]    pend, pend_next;
  logic [P-1:0]  line_cnt, line_cnt_next;
  logic [P-1:0]  col_cnt, col_cnt_next;
  logic [P-1:0]  start_col, start_col_next;
  logic [P-1:0]  run_len, run_len_next;
  logic [KB-1:0] kbuf, kbuf_next;
  logic          drain, drain_next;
  logic [1:0]    n_tok;
  stt_pkg::bundle_t bnd;
  logic          accept;

  function automatic logic [P-1:0] sat_inc(input logic [P-1:0] v);
    return (v == POS_MAX) ? v : v + P'(1);
  endfunction

  function automatic stt_pkg::tok_t make_tok(input logic [4:0] kind,
                                             input logic [P-1:0] ln,
                                             input logic [P-1:0] cl,
                                             input logic [P-1:0] len,
                                             input logic [7:0] bad);
    stt_pkg::tok_t t;
    t.kind   = kind;
    t.line   = 16'(ln);
    t.column = 16'(cl);
    t.length = 16'(len);
    t.bad    = bad;
    return t;
  endfunction

  function automatic logic [4:0] word_kind(input logic [P-1:0] rl, input logic [KB-1:0] kb);
    logic [4:0] k;
    k = stt_pkg::KIND_IDENT;
    for (int i = 0; i < stt_pkg::KW_COUNT; i++) begin
      if (rl == P'(stt_pkg::KW_LEN[i]) && 64'(kb) == stt_pkg::KW_PACKED[i]) begin
        k = stt_pkg::KW_KIND[i];
      end
    end
    return k;
  endfunction

  function automatic logic [4:0] single_kind(input logic [7:0] c);
    logic [4:0] k;
    case (c)
      8'h2B:   k = stt_pkg::KIND_PLUS;
      8'h2D:   k = stt_pkg::KIND_MINUS;
      8'h2A:   k = stt_pkg::KIND_STAR;
      8'h2F:   k = stt_pkg::KIND_SLASH;
      8'h7B:   k = stt_pkg::KIND_LBRACE;
      8'h7D:   k = stt_pkg::KIND_RBRACE;
      8'h28:   k = stt_pkg::KIND_LPAREN;
      8'h29:   k = stt_pkg::KIND_RPAREN;
      8'h2C:   k = stt_pkg::KIND_COMMA;
      default: k = stt_pkg::KIND_ERROR;
    endcase
    return k;
  endfunction

  always_comb begin
    logic       is_dig, is_alp, consumed, is_pair, stop;
    logic [1:0] pc;
    logic [4:0] sk;
    is_dig = (char_byte >= 8'h30) && (char_byte <= 8'h39);
    is_alp = ((char_byte >= 8'h61) && (char_byte <= 8'h7A)) ||
             ((char_byte >= 8'h41) && (char_byte <= 8'h5A));
    is_pair = 1'b1;
    case (char_byte)
      8'h3D:   pc = 2'd0;
      8'h21:   pc = 2'd1;
      8'h3C:   pc = 2'd2;
      8'h3E:   pc = 2'd3;
      default: begin
        pc = 2'd0;
        is_pair = 1'b0;
      end
    endcase
    sk = single_kind(char_byte);

    mode_next      = mode;
    pend_next      = pend;
    line_cnt_next  = line_cnt;
    col_cnt_next   = col_cnt;
    start_col_next = start_col;
    run_len_next   = run_len;
    kbuf_next      = kbuf;
    drain_next     = drain;
    n_tok          = 2'd0;
    bnd            = '0;
    consumed       = 1'b0;
    stop           = 1'b0;

    if (drain) begin
      stop = 1'b1;
      if (final_byte) begin
        drain_next = 1'b0;
      end
    end else begin
      if (mode == stt_pkg::MODE_NUMBER && is_dig) begin
        run_len_next = sat_inc(run_len);
        col_cnt_next = sat_inc(col_cnt);
        consumed = 1'b1;
      end else if (mode == stt_pkg::MODE_WORD && (is_alp || is_dig)) begin
        for (int i = 0; i < KEYWORD_BYTES; i++) begin
          if (run_len == P'(i)) begin
            kbuf_next[8*i +: 8] = kbuf[8*i +: 8] | char_byte;
          end
        end
        run_len_next = sat_inc(run_len);
        col_cnt_next = sat_inc(col_cnt);
        consumed = 1'b1;
      end else if (mode == stt_pkg::MODE_OPERATOR && char_byte == CH_EQ) begin
        bnd.tok[n_tok] = make_tok(stt_pkg::KIND_EQUAL + {2'b0, pend, 1'b0}, line_cnt,
                                  start_col, P'(2), 8'd0);
        n_tok = n_tok + 2'd1;
        col_cnt_next = sat_inc(col_cnt);
        mode_next = stt_pkg::MODE_IDLE;
        consumed = 1'b1;
      end else begin
        // flush the open token
        case (mode)
          stt_pkg::MODE_NUMBER: begin
            bnd.tok[n_tok] = make_tok(stt_pkg::KIND_NUMBER, line_cnt, start_col,
                                      run_len, 8'd0);
            n_tok = n_tok + 2'd1;
          end
          stt_pkg::MODE_WORD: begin
            bnd.tok[n_tok] = make_tok(word_kind(run_len, kbuf), line_cnt, start_col,
                                      run_len, 8'd0);
            n_tok = n_tok + 2'd1;
          end
          stt_pkg::MODE_OPERATOR: begin
            bnd.tok[n_tok] = make_tok(stt_pkg::KIND_ASSIGN + {2'b0, pend, 1'b0}, line_cnt,
                                      start_col, P'(1), 8'd0);
            n_tok = n_tok + 2'd1;
          end
          default: ;
        endcase
        mode_next = stt_pkg::MODE_IDLE;
      end

      if (!consumed) begin
        if (char_byte == CH_NL) begin
          line_cnt_next = sat_inc(line_cnt);
          col_cnt_next  = P'(1);
        end else if (char_byte == CH_SPACE || char_byte == CH_TAB || char_byte == CH_CR) begin
          col_cnt_next = sat_inc(col_cnt);
        end else if (is_dig || is_alp) begin
          mode_next      = is_dig ? stt_pkg::MODE_NUMBER : stt_pkg::MODE_WORD;
          start_col_next = col_cnt;
          run_len_next   = P'(1);
          kbuf_next      = KB'(char_byte);
          col_cnt_next   = sat_inc(col_cnt);
        end else if (is_pair) begin
          mode_next      = stt_pkg::MODE_OPERATOR;
          pend_next      = pc;
          start_col_next = col_cnt;
          col_cnt_next   = sat_inc(col_cnt);
        end else if (sk != stt_pkg::KIND_ERROR) begin
          bnd.tok[n_tok] = make_tok(sk, line_cnt, col_cnt, P'(1), 8'd0);
          n_tok = n_tok + 2'd1;
          col_cnt_next = sat_inc(col_cnt);
        end else begin
          bnd.tok[n_tok] = make_tok(stt_pkg::KIND_ERROR, line_cnt, col_cnt, P'(1),
                                    char_byte);
          n_tok = n_tok + 2'd1;
          stop = 1'b1;
          if (!final_byte) begin
            drain_next = 1'b1;
          end
        end
      end

      if (final_byte && !stop) begin
        case (mode_next)
          stt_pkg::MODE_NUMBER: begin
            bnd.tok[n_tok] = make_tok(stt_pkg::KIND_NUMBER, line_cnt_next, start_col_next,
                                      run_len_next, 8'd0);
            n_tok = n_tok + 2'd1;
          end
          stt_pkg::MODE_WORD: begin
            bnd.tok[n_tok] = make_tok(word_kind(run_len_next, kbuf_next), line_cnt_next,
                                      start_col_next, run_len_next, 8'd0);
            n_tok = n_tok + 2'd1;
          end
          stt_pkg::MODE_OPERATOR: begin
            bnd.tok[n_tok] = make_tok(stt_pkg::KIND_ASSIGN + {2'b0, pend_next, 1'b0},
                                      line_cnt_next, start_col_next, P'(1), 8'd0);
            n_tok = n_tok + 2'd1;
          end
          default: ;
        endcase
        bnd.tok[n_tok] = make_tok(stt_pkg::KIND_END, line_cnt_next, col_cnt_next,
                                  P'(0), 8'd0);
        n_tok = n_tok + 2'd1;
      end
    end

    // end of source: back to the reset state
    if (final_byte && !drain_next) begin
      mode_next      = stt_pkg::MODE_IDLE;
      pend_next      = 2'd0;
      line_cnt_next  = P'(1);
      col_cnt_next   = P'(1);
      start_col_next = P'(1);
      run_len_next   = P'(0);
      kbuf_next      = '0;
    end
    bnd.count = n_tok;
  end

  assign in_ready = !q_full;
  assign accept   = in_valid && in_ready;
  assign q_push   = accept && (n_tok != 2'd0);
  assign q_data   = bnd;

  always_ff @(posedge clk) begin
    if (rst) begin
      mode      <= stt_pkg::MODE_IDLE;
      pend      <= 2'd0;
      line_cnt  <= P'(1);
      col_cnt   <= P'(1);
      start_col <= P'(1);
      run_len   <= P'(0);
      kbuf      <= '0;
      drain     <= 1'b0;
    end else if (accept) begin
      mode      <= mode_next;
      pend      <= pend_next;
      line_cnt  <= line_cnt_next;
      col_cnt   <= col_cnt_next;
      start_col <= start_col_next;
      run_len   <= run_len_next;
      kbuf      <= kbuf_next;
      drain     <= drain_next;
    end
  end

endmodule

// ===== rtl/stt_queue.sv =====
// ----------------------------------------------------------------------------
// stt_queue: bundle queue
// Short register queue between scanner and token output stage.
// ----------------------------------------------------------------------------
module stt_queue (
  input  logic              clk,
  input  logic              rst,
  input  logic              push,
  input  stt_pkg::bundle_t  push_data,
  output logic              full,
  input  logic              pop,
  output stt_pkg::bundle_t  head,
  output logic              empty
);

  localparam int DEPTH = stt_pkg::QUEUE_DEPTH;
  localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW    = $clog2(DEPTH + 1);

  stt_pkg::bundle_t entry [DEPTH];
  logic [AW-1:0] wr_ptr, rd_ptr;
  logic [CW-1:0] fill;

  function automatic logic [AW-1:0] ptr_inc(input logic [AW-1:0] p);
    return (p == AW'(DEPTH - 1)) ? '0 : p + AW'(1);
  endfunction

  assign full  = (fill == CW'(DEPTH));
  assign empty = (fill == '0);
  assign head  = entry[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      entry[wr_ptr] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      if (push) begin
        wr_ptr <= ptr_inc(wr_ptr);
      end
      if (pop) begin
        rd_ptr <= ptr_inc(rd_ptr);
      end
      if (push && !pop) begin
        fill <= fill + CW'(1);
      end else if (pop && !push) begin
        fill <= fill - CW'(1);
      end
    end
  end

endmodule

// ===== rtl/stt_back.sv =====
// ----------------------------------------------------------------------------
// stt_back: token output stage
// Walks the head bundle one token per transfer and marks the last one.
// ----------------------------------------------------------------------------
module stt_back (
  input  logic              clk,
  input  logic              rst,
  input  stt_pkg::bundle_t  head,
  input  logic              q_empty,
  output logic              q_pop,
  output logic              out_valid,
  input  logic              out_ready,
  output logic [4:0]        token_kind,
  output logic [15:0]       token_line,
  output logic [15:0]       token_column,
  output logic [15:0]       token_length,
  output logic [7:0]        bad_byte,
  output logic              run_last
);

  logic [1:0] idx, idx_next;
  stt_pkg::tok_t cur;
  logic is_last;

  assign cur          = head.tok[idx];
  assign is_last      = (idx == head.count - 2'd1);
  assign out_valid    = !q_empty;
  assign token_kind   = cur.kind;
  assign token_line   = cur.line;
  assign token_column = cur.column;
  assign token_length = cur.length;
  assign bad_byte     = cur.bad;
  assign run_last     = is_last;
  assign q_pop        = out_valid && out_ready && is_last;

  always_comb begin
    idx_next = idx;
    if (out_valid && out_ready) begin
      idx_next = is_last ? 2'd0 : idx + 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      idx <= 2'd0;
    end else begin
      idx <= idx_next;
    end
  end

endmodule

// ===== rtl/source_text_tokenizer_core.sv =====
// ----------------------------------------------------------------------------
// source_text_tokenizer_core: streaming source text tokeniser
// Turns a byte stream into tokens with kind, line, column and length.
// ----------------------------------------------------------------------------
// Input channel: one source byte per transfer (char_byte) with final_byte on
// the last byte of a source. Output channel: one token per transfer; run_last
// marks the last token that a given input byte causes. A byte may cause no
// token (whitespace, the inside of a word) or up to three (open token, the
// byte's own token, end marker).
// The tokens of a byte are registered in the queue and offered in order,
// one per transfer. Throughput: one byte per cycle while each byte gives
// at most one token and the receiver is ready; a byte with more tokens
// holds the single token output port for one transfer per token.
// A two-entry queue parts scanner and output stage, so input is still taken
// while the receiver stalls, until both entries are full.
// Reset: synchronous, active high; line and column return to 1, the scanner
// to idle and the queue to empty. A final byte restores all but the queue.
// ----------------------------------------------------------------------------
module source_text_tokenizer_core #(
  parameter int POSITION_BITS = 16,
  parameter int KEYWORD_BYTES = 6
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  char_byte,
  input  logic        final_byte,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [4:0]  token_kind,
  output logic [15:0] token_line,
  output logic [15:0] token_column,
  output logic [15:0] token_length,
  output logic [7:0]  bad_byte,
  output logic        run_last
);

  logic             q_full, q_push, q_pop, q_empty;
  stt_pkg::bundle_t q_data, q_head;

  // scanner: classify each byte and build its token bundle
  stt_front #(
    .POSITION_BITS (POSITION_BITS),
    .KEYWORD_BYTES (KEYWORD_BYTES)
  ) u_front (
    .clk        (clk),
    .rst        (rst),
    .char_byte  (char_byte),
    .final_byte (final_byte),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .q_full     (q_full),
    .q_push     (q_push),
    .q_data     (q_data)
  );

  // hold bundles while the receiver stalls
  stt_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (q_push),
    .push_data (q_data),
    .full      (q_full),
    .pop       (q_pop),
    .head      (q_head),
    .empty     (q_empty)
  );

  // advance through the head bundle, one token per transfer
  stt_back u_back (
    .clk          (clk),
    .rst          (rst),
    .head         (q_head),
    .q_empty      (q_empty),
    .q_pop        (q_pop),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .token_kind   (token_kind),
    .token_line   (token_line),
    .token_column (token_column),
    .token_length (token_length),
    .bad_byte     (bad_byte),
    .run_last     (run_last)
  );

endmodule
